// ----- hw/rtl/sobel_edge_magnitude_3x3_top_assert.svh -----
// Assertion macros for the Sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_TOP_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_TOP_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define SEM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define SEM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/sem_pkg.sv -----
// Package: shared types and constants of the Sobel edge magnitude block
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;
   localparam int SEM_MAX_WIDTH    = 1024;
   localparam int SEM_WIDTH_BITS   = 11;
   localparam int SEM_HEIGHT_BITS  = 16;
   localparam int SEM_ROW_BITS     = 17;
   localparam int SEM_MIN_WIDTH    = 3;
   localparam int SEM_SUM_BITS     = 21;
   localparam int SEM_GRAD_BITS    = 12;
   localparam int SEM_ADDR_BITS    = 3;
   localparam int SEM_DATA_BITS    = 32;
   localparam logic [SEM_WIDTH_BITS-1:0]  SEM_WIDTH_RESET  = 11'd640;
   localparam logic [SEM_HEIGHT_BITS-1:0] SEM_HEIGHT_RESET = 16'd480;
   localparam logic [SEM_SUM_BITS-1:0]    SEM_SAT_LIMIT    = 21'd65025;
   localparam logic [7:0]                 SEM_PIX_MAX      = 8'd255;

   typedef logic [23:0]      sem_rgb_type;
   typedef logic [8:0][23:0] sem_win_type;
   typedef logic [2:0][7:0]  sem_mag_type;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } sem_reg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sem_mag_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MAG,
      ST_FIN
   } sem_state_type;

   typedef enum logic [1:0] {
      MG_IDLE,
      MG_SQ,
      MG_ROOT,
      MG_DONE
   } sem_mag_state_type;
endpackage
`default_nettype wire

// ----- hw/rtl/sem_mag.sv -----
// Sobel gradients, squared sum and bit-serial square root for three channels
`timescale 1ns / 1ps
`default_nettype none
module sem_mag
   import sem_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire sem_win_type      calc,
   output sem_mag_stat_type      stat,
   output sem_mag_type           mag
);
   sem_mag_state_type mg_state_ff, mg_state_in;
   logic signed [SEM_GRAD_BITS-1:0] gx_ff [3];
   logic signed [SEM_GRAD_BITS-1:0] gx_in [3];
   logic signed [SEM_GRAD_BITS-1:0] gy_ff [3];
   logic signed [SEM_GRAD_BITS-1:0] gy_in [3];
   logic [SEM_SUM_BITS-1:0] s_ff [3];
   logic [SEM_SUM_BITS-1:0] s_in [3];
   logic [7:0] res_ff [3];
   logic [7:0] res_in [3];
   logic [2:0] step_ff, step_in;

   function automatic logic signed [SEM_GRAD_BITS-1:0] px(sem_win_type w, int i, int k);
      return $signed({4'b0, w[i][8*k +: 8]});
   endfunction

   always_comb begin
      mg_state_in = mg_state_ff;
      unique case (mg_state_ff)
         MG_IDLE, MG_DONE: begin
            if (start) mg_state_in = MG_SQ;
         end
         MG_SQ:   mg_state_in = MG_ROOT;
         MG_ROOT: begin
            if (step_ff == 3'd0) mg_state_in = MG_DONE;
         end
         default: mg_state_in = MG_IDLE;
      endcase
   end

   always_comb begin
      stat.busy = (mg_state_ff == MG_SQ) || (mg_state_ff == MG_ROOT);
      stat.done = (mg_state_ff == MG_DONE);
   end

   always_comb begin
      logic signed [23:0] sqx;
      logic signed [23:0] sqy;
      logic [7:0]         t;
      logic [15:0]        tt;
      step_in = step_ff;
      for (int k = 0; k < 3; k++) begin
         gx_in[k]  = gx_ff[k];
         gy_in[k]  = gy_ff[k];
         s_in[k]   = s_ff[k];
         res_in[k] = res_ff[k];
         sqx = gx_ff[k] * gx_ff[k];
         sqy = gy_ff[k] * gy_ff[k];
         t   = res_ff[k] | (8'd1 << step_ff);
         tt  = t * t;
         if (start && (mg_state_ff == MG_IDLE || mg_state_ff == MG_DONE)) begin
            gx_in[k] = (px(calc, 6, k) - px(calc, 0, k))
                     + ((px(calc, 7, k) - px(calc, 1, k)) <<< 1)
                     + (px(calc, 8, k) - px(calc, 2, k));
            gy_in[k] = (px(calc, 2, k) - px(calc, 0, k))
                     + ((px(calc, 5, k) - px(calc, 3, k)) <<< 1)
                     + (px(calc, 8, k) - px(calc, 6, k));
         end else if (mg_state_ff == MG_SQ) begin
            s_in[k]   = SEM_SUM_BITS'(sqx) + SEM_SUM_BITS'(sqy);
            res_in[k] = 8'd0;
         end else if (mg_state_ff == MG_ROOT) begin
            if ({5'b0, tt} <= s_ff[k]) res_in[k] = t;
         end
         mag[k] = (s_ff[k] >= SEM_SAT_LIMIT) ? SEM_PIX_MAX : res_ff[k];
      end
      if (mg_state_ff == MG_SQ) step_in = 3'd7;
      else if (mg_state_ff == MG_ROOT) step_in = step_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mg_state_ff <= MG_IDLE;
      end else begin
         mg_state_ff <= mg_state_in;
      end
      step_ff <= step_in;
      for (int k = 0; k < 3; k++) begin
         gx_ff[k]  <= gx_in[k];
         gy_ff[k]  <= gy_in[k];
         s_ff[k]   <= s_in[k];
         res_ff[k] <= res_in[k];
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/sobel_edge_magnitude_3x3_top.sv -----
// Top level: line stores, 3x3 window, frame counters and ports of the Sobel block
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | pix_red, pix_green, pix_blue, drain
//  rsp     | out       | rsp_valid/rsp_ready | edge_red, edge_green, edge_blue, frame_done
//  csr     | in/out    | APB, pready tied 1  | frame_width @0x0, frame_height @0x4
//
// A drain inside the frame is taken without leaving ST_IDLE; an item without a result
// passes ST_READ only. An item with a result goes through store read, gradients, squares
// and an 8-step bit-serial square root. Line stores are synchronous memories.
// Reset is synchronous; the line stores are not cleared. A stalled rsp holds its result
// in its register; the next item is taken meanwhile, but its finished result waits in ST_FIN.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude_3x3_top
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = SEM_MAX_WIDTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [7:0]               req_pix_red,
   input  wire logic [7:0]               req_pix_green,
   input  wire logic [7:0]               req_pix_blue,
   input  wire logic                     req_drain,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [7:0]                    rsp_edge_red,
   output logic [7:0]                    rsp_edge_green,
   output logic [7:0]                    rsp_edge_blue,
   output logic                          rsp_frame_done,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [SEM_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [SEM_DATA_BITS-1:0] csr_pwdata,
   output logic [SEM_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > SEM_WIDTH_BITS) ? CW + 1 : SEM_WIDTH_BITS;

   sem_state_type state_ff, state_in;
   logic [SEM_WIDTH_BITS-1:0]  frame_width_ff, frame_width_in;
   logic [SEM_HEIGHT_BITS-1:0] frame_height_ff, frame_height_in;
   logic [CW-1:0]              col_ff, col_in;
   logic [SEM_ROW_BITS-1:0]    row_ff, row_in;
   sem_win_type                win_ff, win_in, calc;
   sem_rgb_type                pix_ff, pix_in;
   logic                       done_ff, done_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   sem_mag_type                rsp_mag_ff, rsp_mag_in, mag;
   logic                       rsp_done_ff, rsp_done_in;
   sem_rgb_type                mem_a [MAX_WIDTH];
   sem_rgb_type                mem_b [MAX_WIDTH];
   sem_rgb_type                rd_a_ff, rd_b_ff;
   sem_mag_stat_type           mag_stat;

   logic [WW-1:0]           fw_ext, w_eff, col_plus;
   logic [SEM_ROW_BITS-1:0] h_eff;
   logic in_frame, mid_ok, top_ok, col_zero, emit, frame_end, last_col;
   logic req_acc, cfg_wr, mem_wr, mag_start, rsp_load;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign req_acc    = req_valid && req_ready;

   always_comb begin
      unique case (sem_reg_type'(csr_paddr[2]))
         REG_FRAME_WIDTH:  csr_prdata = SEM_DATA_BITS'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = SEM_DATA_BITS'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      fw_ext = WW'(frame_width_ff);
      priority if (fw_ext < WW'(SEM_MIN_WIDTH)) w_eff = WW'(SEM_MIN_WIDTH);
      else if (fw_ext > WW'(MAX_WIDTH))         w_eff = WW'(MAX_WIDTH);
      else                                      w_eff = fw_ext;
      h_eff     = (frame_height_ff == '0) ? SEM_ROW_BITS'(1) : SEM_ROW_BITS'(frame_height_ff);
      in_frame  = row_ff < h_eff;
      mid_ok    = (row_ff != '0) && (row_ff <= h_eff);
      top_ok    = row_ff >= SEM_ROW_BITS'(2);
      col_zero  = col_ff == '0;
      emit      = col_zero ? top_ok : mid_ok;
      frame_end = col_zero && (row_ff == h_eff + SEM_ROW_BITS'(1));
      col_plus  = WW'(col_ff) + WW'(1);
      last_col  = col_plus >= w_eff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && !(req_drain && in_frame)) state_in = ST_READ;
         end
         ST_READ: state_in = emit ? ST_MAG : ST_IDLE;
         ST_MAG: begin
            if (mag_stat.done) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mem_wr    = (state_ff == ST_READ);
      mag_start = (state_ff == ST_READ) && emit;
      rsp_load  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      win_in  = win_ff;
      calc    = win_ff;
      pix_in  = pix_ff;
      done_in = done_ff;
      if (req_acc) begin
         pix_in = in_frame ? {req_pix_blue, req_pix_green, req_pix_red} : '0;
      end
      if (cfg_wr) begin
         unique case (sem_reg_type'(csr_paddr[2]))
            REG_FRAME_WIDTH:  frame_width_in  = csr_pwdata[SEM_WIDTH_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_pwdata[SEM_HEIGHT_BITS-1:0];
            default: ;
         endcase
         col_in = '0;
         row_in = '0;
         win_in = '0;
      end else if (state_ff == ST_READ) begin
         for (int i = 0; i < 6; i++) begin
            calc[i]   = win_ff[i+3];
            win_in[i] = col_zero ? '0 : win_ff[i+3];
         end
         for (int i = 6; i < 9; i++) calc[i] = '0;
         win_in[6] = top_ok ? rd_b_ff : '0;
         win_in[7] = mid_ok ? rd_a_ff : '0;
         win_in[8] = pix_ff;
         if (!col_zero) calc = win_in;
         if (last_col) begin
            col_in = '0;
            row_in = row_ff + SEM_ROW_BITS'(1);
         end else begin
            col_in = CW'(col_plus);
         end
         done_in = frame_end;
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
            win_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_done_in  = rsp_done_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_mag_in   = mag;
         rsp_done_in  = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem_a[col_ff] <= pix_ff;
         mem_b[col_ff] <= rd_a_ff;
      end
      if (req_acc) begin
         rd_a_ff <= mem_a[col_ff];
         rd_b_ff <= mem_b[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_width_ff  <= SEM_WIDTH_RESET;
         frame_height_ff <= SEM_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         win_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         win_ff          <= win_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      pix_ff      <= pix_in;
      done_ff     <= done_in;
      rsp_mag_ff  <= rsp_mag_in;
      rsp_done_ff <= rsp_done_in;
   end

   sem_mag u_mag (
      .clock (clock),
      .reset (reset),
      .start (mag_start),
      .calc  (calc),
      .stat  (mag_stat),
      .mag   (mag)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_red   = rsp_mag_ff[0];
   assign rsp_edge_green = rsp_mag_ff[1];
   assign rsp_edge_blue  = rsp_mag_ff[2];
   assign rsp_frame_done = rsp_done_ff;

`include "sobel_edge_magnitude_3x3_top_assert.svh"
   `SEM_ASSERT_NXT(a_fin_hold, state_ff == ST_FIN && rsp_valid_ff && !rsp_ready, state_ff == ST_FIN, "result finished over a stalled transfer")
   `SEM_ASSERT_IMP(a_mag_owner, mag_stat.busy, state_ff == ST_MAG, "magnitude unit busy outside magnitude state")
   `SEM_ASSERT_IMP(a_col_range, 1'b1, WW'(col_ff) < w_eff, "column counter beyond row width")
   `SEM_ASSERT_NXT(a_read_next, req_acc && !(req_drain && in_frame), state_ff == ST_READ, "accepted item not read")
endmodule
`default_nettype wire
